[hdl/tile_dedup_flip_table_core_assert.svh]
// Assertion macros for the tile dedup core checker.
// Depends on nothing; included by the checker file only.
`ifndef TILE_DEDUP_FLIP_TABLE_CORE_ASSERT_SVH
`define TILE_DEDUP_FLIP_TABLE_CORE_ASSERT_SVH

// Check a property outside reset.
`define TDF_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("tdf assertion failed");

// Check a property at every edge, reset included.
`define TDF_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("tdf assertion failed");

`endif

[hdl/tdf_pkg.sv]
// Shared types, constants and helpers of the tile dedup core.
// No dependencies; used by the front, back and top level.
`timescale 1ns / 1ps
package tdf_pkg;

  localparam int TILE_LIMIT = 1023;
  localparam int SLOT_W     = 10;
  localparam int ROW_W      = 64;
  localparam int Y_W        = 3;
  localparam int TILE_DEPTH = TILE_LIMIT * 8;

  localparam logic [1:0] CMD_FIND    = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_PRELOAD = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ADDED  = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;

  localparam logic REG_ALLOW_FLIP  = 1'b0;
  localparam logic REG_SIZE_LOCKED = 1'b1;

  typedef enum logic [2:0] {
    K_ROW,
    K_FIND,
    K_PRELOAD,
    K_FREE,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ROW_W-1:0]  row;
    logic [3:0]        pal;
    logic [SLOT_W-1:0] slot;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_t;

  typedef struct packed {
    logic en;
    logic index;
    logic data;
  } cfg_wr_t;

  function automatic logic [ROW_W-1:0] mirror_row(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] o;
    o = '0;
    for (int k = 0; k < 8; k++) begin
      o[8*(7-k) +: 8] = r[8*k +: 8];
    end
    return o;
  endfunction

endpackage

[hdl/tdf_front.sv]
// Front part: classify each command beat and queue it for the back part.
// Depends on tdf_pkg.
`timescale 1ns / 1ps
module tdf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                cmd,
  input  logic [tdf_pkg::ROW_W-1:0] row_pixels,
  input  logic [3:0]                palette,
  input  logic [tdf_pkg::SLOT_W-1:0] slot,
  output logic                      busy,
  output tdf_pkg::q_t               q,
  input  logic                      take
);

  tdf_pkg::op_t ent [2];
  tdf_pkg::op_t op_new;
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic [2:0]   row_cnt;
  logic         push;

  assign busy    = (cnt == 2'd2);
  assign push    = start && !busy;
  assign q.valid = (cnt != 2'd0);
  assign q.op    = ent[rp];

  always_comb begin
    op_new.row  = row_pixels;
    op_new.pal  = palette;
    op_new.slot = slot;
    case (cmd)
      tdf_pkg::CMD_FREE:  op_new.kind = tdf_pkg::K_FREE;
      tdf_pkg::CMD_CLEAR: op_new.kind = tdf_pkg::K_CLEAR;
      tdf_pkg::CMD_FIND: begin
        op_new.kind = (row_cnt == 3'd7) ? tdf_pkg::K_FIND : tdf_pkg::K_ROW;
      end
      default: begin
        op_new.kind = (row_cnt == 3'd7) ? tdf_pkg::K_PRELOAD : tdf_pkg::K_ROW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= op_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= 1'b0;
      rp      <= 1'b0;
      cnt     <= 2'd0;
      row_cnt <= 3'd0;
    end else begin
      if (push) begin
        wp <= !wp;
        case (op_new.kind)
          tdf_pkg::K_CLEAR: row_cnt <= 3'd0;
          tdf_pkg::K_FREE:  row_cnt <= row_cnt;
          default:          row_cnt <= row_cnt + 3'd1;
        endcase
      end
      if (take) begin
        rp <= !rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

[hdl/tdf_back.sv]
// Back part: tile store, slot search, add, preload, free with trim, clear.
// Depends on tdf_pkg; fed by tdf_front.
`timescale 1ns / 1ps
module tdf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tdf_pkg::q_t                 q,
  output logic                        take,
  input  tdf_pkg::cfg_wr_t            cfg,
  output logic                        done,
  output logic [tdf_pkg::SLOT_W-1:0]  tile_index,
  output logic                        hflip,
  output logic                        vflip,
  output logic [3:0]                  palette_out,
  output logic [1:0]                  status
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SEARCH  = 6'b000010,
    S_ADD     = 6'b000100,
    S_WRITE   = 6'b001000,
    S_TRIM_RD = 6'b010000,
    S_TRIM_CK = 6'b100000
  } state_t;

  localparam logic [tdf_pkg::SLOT_W-1:0] LIMIT = tdf_pkg::SLOT_W'(tdf_pkg::TILE_LIMIT);
  localparam logic [tdf_pkg::SLOT_W-1:0] ONE   = tdf_pkg::SLOT_W'(1);

  state_t state;

  logic [tdf_pkg::ROW_W-1:0] inc    [8];
  logic [tdf_pkg::ROW_W-1:0] inc_sh [8];
  logic [tdf_pkg::ROW_W-1:0] wf     [8];
  logic [tdf_pkg::ROW_W-1:0] wr     [8];

  logic [tdf_pkg::ROW_W-1:0] tile_mem [tdf_pkg::TILE_DEPTH];
  logic                      free_mem [tdf_pkg::TILE_LIMIT];

  logic [tdf_pkg::ROW_W-1:0]  t_rdata;
  logic                       t_we;
  logic [tdf_pkg::SLOT_W+tdf_pkg::Y_W-1:0] t_waddr;
  logic [tdf_pkg::SLOT_W+tdf_pkg::Y_W-1:0] t_raddr;
  logic                       f_rdata;
  logic                       f_we;
  logic                       f_wdata;
  logic [tdf_pkg::SLOT_W-1:0] f_waddr;
  logic [tdf_pkg::SLOT_W-1:0] f_raddr;

  logic [tdf_pkg::SLOT_W-1:0] size;
  logic                       locked;
  logic                       allow;
  logic [tdf_pkg::SLOT_W-1:0] rd_s;
  logic [tdf_pkg::Y_W-1:0]    rd_y;
  logic                       iss;
  logic                       dv;
  logic [tdf_pkg::Y_W-1:0]    dv_y;
  logic [tdf_pkg::SLOT_W-1:0] dv_s;
  logic                       a_ex, a_v, a_h, a_hv;
  logic                       f_ex, f_v, f_h, f_hv;
  logic                       hit;
  logic                       ffv;
  logic [tdf_pkg::SLOT_W-1:0] ffi;
  logic [tdf_pkg::SLOT_W-1:0] pos;
  logic [tdf_pkg::Y_W-1:0]    wcnt;
  logic [3:0]                 pal_r;
  logic                       last_slot;

  assign take      = (state == S_IDLE) && q.valid;
  assign last_slot = (dv_s == size - ONE);

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      inc_sh[i] = inc[i+1];
    end
    inc_sh[7] = q.op.row;
  end

  // Compare this stored row against all four orientations at once.
  always_comb begin
    logic first;
    first = (dv_y == '0);
    f_ex  = (first || a_ex) && (t_rdata == wf[0]);
    f_v   = (first || a_v)  && (t_rdata == wr[7]);
    f_h   = (first || a_h)  && (t_rdata == tdf_pkg::mirror_row(wf[0]));
    f_hv  = (first || a_hv) && (t_rdata == tdf_pkg::mirror_row(wr[7]));
    hit   = f_ex || (allow && (f_v || f_h || f_hv));
  end

  assign t_we    = (state == S_WRITE);
  assign t_waddr = {pos, wcnt};
  assign t_raddr = {rd_s, rd_y};
  assign f_raddr = (state == S_TRIM_RD) ? size - ONE : rd_s;

  always_comb begin
    f_we    = 1'b0;
    f_wdata = 1'b0;
    f_waddr = pos;
    if (take && (q.op.kind == tdf_pkg::K_FREE) && (q.op.slot < size)) begin
      f_we    = 1'b1;
      f_wdata = 1'b1;
      f_waddr = q.op.slot;
    end else if ((state == S_SEARCH) && dv && (dv_y == 3'd7) && hit) begin
      f_we    = 1'b1;
      f_waddr = dv_s;
    end else if ((state == S_WRITE) && (wcnt == 3'd7)) begin
      f_we    = 1'b1;
      f_waddr = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tile_mem[t_waddr] <= wf[0];
    end
    t_rdata <= tile_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      free_mem[f_waddr] <= f_wdata;
    end
    f_rdata <= free_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      size   <= '0;
      locked <= 1'b0;
      allow  <= 1'b0;
      done   <= 1'b0;
      iss    <= 1'b0;
      dv     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg.en) begin
        case (cfg.index)
          tdf_pkg::REG_ALLOW_FLIP: allow  <= cfg.data;
          default:                 locked <= cfg.data;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            pal_r <= q.op.pal;
            case (q.op.kind)
              tdf_pkg::K_ROW: inc <= inc_sh;
              tdf_pkg::K_FIND: begin
                inc <= inc_sh;
                wf  <= inc_sh;
                wr  <= inc_sh;
                ffv <= 1'b0;
                if (size == '0) begin
                  state <= S_ADD;
                end else begin
                  rd_s  <= '0;
                  rd_y  <= '0;
                  iss   <= 1'b1;
                  dv    <= 1'b0;
                  state <= S_SEARCH;
                end
              end
              tdf_pkg::K_PRELOAD: begin
                inc <= inc_sh;
                wf  <= inc_sh;
                if (locked || (size >= LIMIT)) begin
                  done        <= 1'b1;
                  tile_index  <= '0;
                  hflip       <= 1'b0;
                  vflip       <= 1'b0;
                  palette_out <= q.op.pal;
                  status      <= tdf_pkg::ST_NOROOM;
                end else begin
                  pos   <= size;
                  wcnt  <= '0;
                  state <= S_WRITE;
                end
              end
              tdf_pkg::K_FREE: begin
                if ((q.op.slot < size) && !locked) begin
                  state <= S_TRIM_RD;
                end
              end
              default: begin
                size   <= '0;
                locked <= 1'b0;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (iss) begin
            rd_y <= rd_y + 3'd1;
            if (rd_y == 3'd7) begin
              if (rd_s == size - ONE) begin
                iss <= 1'b0;
              end else begin
                rd_s <= rd_s + ONE;
              end
            end
          end
          dv   <= iss;
          dv_y <= rd_y;
          dv_s <= rd_s;
          if (dv) begin
            for (int i = 0; i < 7; i++) begin
              wf[i]   <= wf[i+1];
              wr[i+1] <= wr[i];
            end
            wf[7] <= wf[0];
            wr[0] <= wr[7];
            a_ex  <= f_ex;
            a_v   <= f_v;
            a_h   <= f_h;
            a_hv  <= f_hv;
            if ((dv_y == '0) && f_rdata && !ffv) begin
              ffv <= 1'b1;
              ffi <= dv_s;
            end
            if (dv_y == 3'd7) begin
              if (hit) begin
                done        <= 1'b1;
                tile_index  <= dv_s;
                hflip       <= !f_ex && !f_v && (f_h || f_hv);
                vflip       <= !f_ex && (f_v || (!f_h && f_hv));
                palette_out <= pal_r;
                status      <= tdf_pkg::ST_FOUND;
                iss         <= 1'b0;
                dv          <= 1'b0;
                state       <= S_IDLE;
              end else if (last_slot) begin
                dv    <= 1'b0;
                state <= S_ADD;
              end
            end
          end
        end
        S_ADD: begin
          wf <= inc;
          if (!ffv && ((size >= LIMIT) || locked)) begin
            done        <= 1'b1;
            tile_index  <= '0;
            hflip       <= 1'b0;
            vflip       <= 1'b0;
            palette_out <= pal_r;
            status      <= tdf_pkg::ST_NOROOM;
            state       <= S_IDLE;
          end else begin
            pos   <= ffv ? ffi : size;
            wcnt  <= '0;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          for (int i = 0; i < 7; i++) begin
            wf[i] <= wf[i+1];
          end
          wf[7] <= wf[0];
          wcnt  <= wcnt + 3'd1;
          if (wcnt == 3'd7) begin
            if (pos == size) begin
              size <= size + ONE;
            end
            done        <= 1'b1;
            tile_index  <= pos;
            hflip       <= 1'b0;
            vflip       <= 1'b0;
            palette_out <= pal_r;
            status      <= tdf_pkg::ST_ADDED;
            state       <= S_IDLE;
          end
        end
        S_TRIM_RD: begin
          state <= (size == '0) ? S_IDLE : S_TRIM_CK;
        end
        S_TRIM_CK: begin
          if (f_rdata) begin
            size  <= size - ONE;
            state <= S_TRIM_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/tile_dedup_flip_table_core.sv]
// A find searches the slots in order and reports a hit, else adds the tile (at once
// on an empty table) or reports no room; it reads the tile store once per stored
// row up to the first hit. A preload adds the tile unless there is no room. Row
// beats flow at one per cycle while the front part is not busy. A free marks an
// in-range slot free and, unless locked, trims freed slots off the table end. The
// receiver cannot stall. Reset (rst, synchronous) empties the table, clears config.
`timescale 1ns / 1ps
module tile_dedup_flip_table_core (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [tdf_pkg::ROW_W-1:0]   row_pixels,
  input  logic [3:0]                  palette,
  input  logic [tdf_pkg::SLOT_W-1:0]  slot,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic                        cfg_data,
  // result beat
  output logic                        done,
  output logic [tdf_pkg::SLOT_W-1:0]  tile_index,
  output logic                        hflip,
  output logic                        vflip,
  output logic [3:0]                  palette_out,
  output logic [1:0]                  status
);

  tdf_pkg::q_t      q;
  tdf_pkg::cfg_wr_t cfg;
  logic             take;

  // Registers are plain flops; accept writes every cycle.
  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: classify command beats (row, tile end, free, clear) and queue them.
  tdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .row_pixels (row_pixels),
    .palette    (palette),
    .slot       (slot),
    .busy       (busy),
    .q          (q),
    .take       (take)
  );

  // Back: hold the tile store, search slots in order, add, preload, free, trim and clear.
  tdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q           (q),
    .take        (take),
    .cfg         (cfg),
    .done        (done),
    .tile_index  (tile_index),
    .hflip       (hflip),
    .vflip       (vflip),
    .palette_out (palette_out),
    .status      (status)
  );

endmodule

[hdl/tdf_checker.sv]
// Port-level checks of the tile dedup core, bound to the top level.
// Depends on tdf_pkg and tile_dedup_flip_table_core_assert.svh.
`timescale 1ns / 1ps
`include "tile_dedup_flip_table_core_assert.svh"
module tdf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       done,
  input logic [tdf_pkg::SLOT_W-1:0] tile_index,
  input logic                       hflip,
  input logic                       vflip,
  input logic [1:0]                 status
);

  `TDF_ASSERT(a_status_code, clk, rst, done |-> (status == tdf_pkg::ST_FOUND || status == tdf_pkg::ST_ADDED || status == tdf_pkg::ST_NOROOM))
  `TDF_ASSERT(a_noroom_zero, clk, rst, (done && status == tdf_pkg::ST_NOROOM) |-> (tile_index == '0 && !hflip && !vflip))
  `TDF_ASSERT(a_added_noflip, clk, rst, (done && status == tdf_pkg::ST_ADDED) |-> (!hflip && !vflip))
  `TDF_ASSERT_ALWAYS(a_quiet_after_reset, clk, $past(rst) |-> !done)

endmodule

bind tile_dedup_flip_table_core tdf_checker u_tdf_checker (
  .clk        (clk),
  .rst        (rst),
  .done       (done),
  .tile_index (tile_index),
  .hflip      (hflip),
  .vflip      (vflip),
  .status     (status)
);
